// ===== design/assert_macros.svh =====
// assertion macros shared by the converter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define PPC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PPC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/ppc_pkg.sv =====
// shared types, constants and index wrap function of the palette pixel converter
// no dependencies
`default_nettype none

package ppc_pkg;

   localparam int INPUT_PLANES    = 6;
   localparam int WORD_BITS       = 16;
   localparam int WORD_SEL_BITS   = 4;
   localparam int INDEX_BITS      = 6;
   localparam int MIDX_BITS       = 12;
   localparam int SLOT_IN_BITS    = 6;
   localparam int SLOT_STORE_BITS = 8;
   localparam int CHAN_BITS       = 8;
   localparam int NIBBLE_BITS     = 4;
   localparam int COLOUR_BITS     = 12;
   localparam int POS_BITS        = 6;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = 1;
   localparam int RECIP_BITS      = 14;

   typedef enum logic [1:0] {
      ACT_MASTER  = 2'd0,
      ACT_SLOT    = 2'd1,
      ACT_CONVERT = 2'd2
   } action_type;

   typedef logic [INPUT_PLANES-1:0][WORD_BITS-1:0] planes_type;

   typedef struct packed {
      action_type                 action;
      logic [MIDX_BITS-1:0]       master_index;
      logic [SLOT_STORE_BITS-1:0] palette_slot;
      logic [COLOUR_BITS-1:0]     colour;
      planes_type                 planes;
   } op_type;

   typedef struct packed {
      logic   push;
      op_type op;
   } push_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } head_type;

   // remainder by reciprocal multiplication, exact for any value below 2**MIDX_BITS
   function automatic logic [MIDX_BITS-1:0] wrap_index(input logic [MIDX_BITS-1:0] value,
                                                        input int unsigned modulus);
      int unsigned                     shift;
      logic [RECIP_BITS-1:0]           recip;
      logic [MIDX_BITS+RECIP_BITS-1:0] product;
      logic [MIDX_BITS-1:0]            quotient;
      logic [2*MIDX_BITS:0]            multiple;
      shift    = MIDX_BITS + $clog2(modulus);
      recip    = RECIP_BITS'(((64'd1 << shift) + 64'(modulus) - 64'd1) / 64'(modulus));
      product  = (MIDX_BITS + RECIP_BITS)'(value) * (MIDX_BITS + RECIP_BITS)'(recip);
      quotient = MIDX_BITS'(product >> shift);
      multiple = (2*MIDX_BITS + 1)'(quotient) * (2*MIDX_BITS + 1)'(modulus);
      return value - multiple[MIDX_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/ppc_ram.sv =====
// generic simple dual port ram with registered read
// no dependencies
`default_nettype none

module ppc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/ppc_front.sv =====
// front end: classifies incoming items, wraps indices and packs queue entries
// depends on ppc_pkg
`default_nettype none

module ppc_front #(
   parameter int MASTER_ENTRIES = 4096,
   parameter int ACTIVE_ENTRIES = 64
) (
   input  wire logic                             req_valid,
   input  wire logic [1:0]                       req_action,
   input  wire logic [ppc_pkg::MIDX_BITS-1:0]    req_master_index,
   input  wire logic [ppc_pkg::SLOT_IN_BITS-1:0] req_palette_slot,
   input  wire logic [ppc_pkg::CHAN_BITS-1:0]    req_red_in,
   input  wire logic [ppc_pkg::CHAN_BITS-1:0]    req_green_in,
   input  wire logic [ppc_pkg::CHAN_BITS-1:0]    req_blue_in,
   input  wire ppc_pkg::planes_type              req_planes,
   input  wire logic                             queue_full,
   output ppc_pkg::push_type                     push
);

   logic [ppc_pkg::MIDX_BITS-1:0] midx_wrap;
   logic [ppc_pkg::MIDX_BITS-1:0] slot_wrap;

   always_comb begin
      midx_wrap = ppc_pkg::wrap_index(req_master_index, MASTER_ENTRIES);
      slot_wrap = ppc_pkg::wrap_index(ppc_pkg::MIDX_BITS'(req_palette_slot), ACTIVE_ENTRIES);
      push.op.action       = ppc_pkg::action_type'(req_action);
      push.op.master_index = midx_wrap;
      push.op.palette_slot = slot_wrap[ppc_pkg::SLOT_STORE_BITS-1:0];
      push.op.colour       = {req_red_in[ppc_pkg::CHAN_BITS-1 -: ppc_pkg::NIBBLE_BITS],
                              req_green_in[ppc_pkg::CHAN_BITS-1 -: ppc_pkg::NIBBLE_BITS],
                              req_blue_in[ppc_pkg::CHAN_BITS-1 -: ppc_pkg::NIBBLE_BITS]};
      push.op.planes       = req_planes;
      // unused action code is taken and dropped
      push.push = req_valid && !queue_full && (req_action inside
                  {ppc_pkg::ACT_MASTER, ppc_pkg::ACT_SLOT, ppc_pkg::ACT_CONVERT});
   end

endmodule

`default_nettype wire

// ===== design/ppc_queue.sv =====
// two entry item queue between front and back end
// depends on ppc_pkg
`default_nettype none

module ppc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ppc_pkg::push_type push,
   input  wire logic              pop,
   output ppc_pkg::head_type      head,
   output logic                   full
);

   ppc_pkg::op_type entry_ff [ppc_pkg::QUEUE_DEPTH];
   logic [ppc_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ppc_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ppc_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (ppc_pkg::QUEUE_PTR_BITS + 1)'(push.push)
                           - (ppc_pkg::QUEUE_PTR_BITS + 1)'(pop);
      full       = count_ff == (ppc_pkg::QUEUE_PTR_BITS + 1)'(ppc_pkg::QUEUE_DEPTH);
      head.valid = count_ff != '0;
      head.op    = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.push) begin
         entry_ff[wr_ptr_ff] <= push.op;
      end
   end

endmodule

`default_nettype wire

// ===== design/ppc_back.sv =====
// back end: palette writes and the pixel pipeline (slot read, master read, output)
// depends on ppc_pkg and ppc_ram
`default_nettype none

module ppc_back #(
   parameter int PLANE_COUNT     = 6,
   parameter int MASTER_ENTRIES  = 4096,
   parameter int ACTIVE_ENTRIES  = 64,
   parameter int PIXELS_PER_WORD = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire ppc_pkg::head_type              head,
   output logic                                pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [ppc_pkg::INDEX_BITS-1:0]      rsp_pixel_index,
   output logic [ppc_pkg::CHAN_BITS-1:0]       rsp_red_out,
   output logic [ppc_pkg::CHAN_BITS-1:0]       rsp_green_out,
   output logic [ppc_pkg::CHAN_BITS-1:0]       rsp_blue_out,
   output logic                                rsp_last_pixel
);

   localparam int MASTER_AW   = $clog2(MASTER_ENTRIES);
   localparam int SLOT_AW     = $clog2(ACTIVE_ENTRIES);
   localparam int PIXEL_CW    = $clog2(PIXELS_PER_WORD);
   localparam int USED_PLANES = (PLANE_COUNT < ppc_pkg::INPUT_PLANES) ?
                                PLANE_COUNT : ppc_pkg::INPUT_PLANES;

   // stage 0: queue head and pixel counter
   logic                          advance;
   logic                          is_pixel, is_slot, is_master, last_k;
   logic [PIXEL_CW-1:0]           pixel_ff, pixel_in;
   logic [ppc_pkg::POS_BITS-1:0]  bit_pos;
   logic [ppc_pkg::INDEX_BITS-1:0] pixel_index;
   logic [ppc_pkg::MIDX_BITS-1:0] slot_wrap;
   logic [SLOT_AW-1:0]            slot_addr;
   logic [SLOT_AW-1:0]            slot_wr_addr;
   logic [ACTIVE_ENTRIES-1:0]     slot_set_ff, slot_set_in;
   logic [MASTER_AW-1:0]          slot_rd_data;

   // stage 1: slot data back, master access
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_pixel_ff, s1_pixel_in;
   logic [ppc_pkg::INDEX_BITS-1:0] s1_index_ff, s1_index_in;
   logic                          s1_last_ff, s1_last_in;
   logic                          s1_set_ff, s1_set_in;
   logic [SLOT_AW-1:0]            s1_slot_ff, s1_slot_in;
   logic [MASTER_AW-1:0]          s1_maddr_ff, s1_maddr_in;
   logic [ppc_pkg::COLOUR_BITS-1:0] s1_colour_ff, s1_colour_in;
   logic [ppc_pkg::MIDX_BITS-1:0] default_wrap;
   logic [MASTER_AW-1:0]          entry;
   logic [ppc_pkg::COLOUR_BITS-1:0] colour;

   // stage 2: output register
   logic                          out_valid_ff, out_valid_in;
   logic [ppc_pkg::INDEX_BITS-1:0] out_index_ff, out_index_in;
   logic                          out_last_ff, out_last_in;

   function automatic logic [ppc_pkg::CHAN_BITS-1:0] expand_nibble(
      input logic [ppc_pkg::NIBBLE_BITS-1:0] nib);
      // times 17
      return {nib, nib};
   endfunction

   always_comb begin
      advance   = !out_valid_ff || !rsp_stall;
      is_pixel  = head.valid && (head.op.action == ppc_pkg::ACT_CONVERT);
      is_slot   = head.valid && (head.op.action == ppc_pkg::ACT_SLOT);
      is_master = head.valid && (head.op.action == ppc_pkg::ACT_MASTER);
      last_k    = pixel_ff == PIXEL_CW'(PIXELS_PER_WORD - 1);
      pop       = advance && head.valid && (!is_pixel || last_k);

      pixel_in = pixel_ff;
      if (advance && is_pixel) begin
         pixel_in = last_k ? '0 : pixel_ff + 1'b1;
      end

      bit_pos = ppc_pkg::POS_BITS'(PIXELS_PER_WORD - 1) - ppc_pkg::POS_BITS'(pixel_ff);
      pixel_index = '0;
      for (int p = 0; p < USED_PLANES; p++) begin
         if (bit_pos < ppc_pkg::POS_BITS'(ppc_pkg::WORD_BITS)) begin
            pixel_index[p] = head.op.planes[p][bit_pos[ppc_pkg::WORD_SEL_BITS-1:0]];
         end
      end
      slot_wrap = ppc_pkg::wrap_index(ppc_pkg::MIDX_BITS'(pixel_index), ACTIVE_ENTRIES);
      slot_addr = slot_wrap[SLOT_AW-1:0];
      slot_wr_addr = head.op.palette_slot[SLOT_AW-1:0];

      slot_set_in = slot_set_ff;
      if (advance && is_slot) begin
         slot_set_in[slot_wr_addr] = 1'b1;
      end

      s1_valid_in  = advance ? (is_pixel || is_master) : s1_valid_ff;
      s1_pixel_in  = advance ? is_pixel : s1_pixel_ff;
      s1_index_in  = advance ? pixel_index : s1_index_ff;
      s1_last_in   = advance ? last_k : s1_last_ff;
      s1_set_in    = advance ? slot_set_ff[slot_addr] : s1_set_ff;
      s1_slot_in   = advance ? slot_addr : s1_slot_ff;
      s1_maddr_in  = advance ? head.op.master_index[MASTER_AW-1:0] : s1_maddr_ff;
      s1_colour_in = advance ? head.op.colour : s1_colour_ff;

      // a slot never written points at the entry of its own number
      default_wrap = ppc_pkg::wrap_index(ppc_pkg::MIDX_BITS'(s1_slot_ff), MASTER_ENTRIES);
      entry = s1_set_ff ? slot_rd_data : default_wrap[MASTER_AW-1:0];

      out_valid_in = advance ? (s1_valid_ff && s1_pixel_ff) : out_valid_ff;
      out_index_in = advance ? s1_index_ff : out_index_ff;
      out_last_in  = advance ? s1_last_ff : out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_ff     <= '0;
         slot_set_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pixel_ff     <= pixel_in;
         slot_set_ff  <= slot_set_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_pixel_ff  <= s1_pixel_in;
      s1_index_ff  <= s1_index_in;
      s1_last_ff   <= s1_last_in;
      s1_set_ff    <= s1_set_in;
      s1_slot_ff   <= s1_slot_in;
      s1_maddr_ff  <= s1_maddr_in;
      s1_colour_ff <= s1_colour_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
   end

   ppc_ram #(
      .WIDTH (MASTER_AW),
      .DEPTH (ACTIVE_ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (advance && is_slot),
      .wr_addr (slot_wr_addr),
      .wr_data (head.op.master_index[MASTER_AW-1:0]),
      .rd_en   (advance && is_pixel),
      .rd_addr (slot_addr),
      .rd_data (slot_rd_data)
   );

   ppc_ram #(
      .WIDTH (ppc_pkg::COLOUR_BITS),
      .DEPTH (MASTER_ENTRIES)
   ) u_master_ram (
      .clock   (clock),
      .wr_en   (advance && s1_valid_ff && !s1_pixel_ff),
      .wr_addr (s1_maddr_ff),
      .wr_data (s1_colour_ff),
      .rd_en   (advance && s1_valid_ff && s1_pixel_ff),
      .rd_addr (entry),
      .rd_data (colour)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_index = out_index_ff;
   assign rsp_last_pixel  = out_last_ff;
   assign rsp_red_out     = expand_nibble(colour[3*ppc_pkg::NIBBLE_BITS-1 -: ppc_pkg::NIBBLE_BITS]);
   assign rsp_green_out   = expand_nibble(colour[2*ppc_pkg::NIBBLE_BITS-1 -: ppc_pkg::NIBBLE_BITS]);
   assign rsp_blue_out    = expand_nibble(colour[ppc_pkg::NIBBLE_BITS-1:0]);

endmodule

`default_nettype wire

// ===== design/planar_palette_pixel_converter_unit.sv =====
// top level of the planar to chunky converter with two level colour palette
// depends on ppc_pkg, ppc_front, ppc_queue, ppc_back, ppc_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// A conversion item yields PIXELS_PER_WORD pixel items, one per cycle while the result side does
// not stall, and holds the back end until its last pixel; a master colour write or a slot write
// yields nothing; an unused action code is taken and dropped. The first pixel is offered once its
// item reaches the head of the two-entry queue and has passed the slot ram read and then the master
// ram read, whose register is the output register. The pixel counter in the back end sets the
// rate. The queue keeps taking items while pixels are produced or the result side stalls, until
// its two entries are full. There is no clearing pass after reset: slots never written read as
// their own number, and master entries must be written before they are used.
module planar_palette_pixel_converter_unit #(
   parameter int PLANE_COUNT     = 6,
   parameter int MASTER_ENTRIES  = 4096,
   parameter int ACTIVE_ENTRIES  = 64,
   parameter int PIXELS_PER_WORD = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [11:0] req_master_index,
   input  wire logic [5:0]  req_palette_slot,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   input  wire logic [15:0] req_plane_word_0,
   input  wire logic [15:0] req_plane_word_1,
   input  wire logic [15:0] req_plane_word_2,
   input  wire logic [15:0] req_plane_word_3,
   input  wire logic [15:0] req_plane_word_4,
   input  wire logic [15:0] req_plane_word_5,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_pixel_index,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic             rsp_last_pixel
);

   ppc_pkg::push_type   push;
   ppc_pkg::head_type   head;
   ppc_pkg::planes_type planes;
   logic                pop;
   logic                queue_full;

   assign planes = {req_plane_word_5, req_plane_word_4, req_plane_word_3,
                    req_plane_word_2, req_plane_word_1, req_plane_word_0};
   assign req_stall = queue_full;

   ppc_front #(
      .MASTER_ENTRIES (MASTER_ENTRIES),
      .ACTIVE_ENTRIES (ACTIVE_ENTRIES)
   ) u_front (
      .req_valid        (req_valid),
      .req_action       (req_action),
      .req_master_index (req_master_index),
      .req_palette_slot (req_palette_slot),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_planes       (planes),
      .queue_full       (queue_full),
      .push             (push)
   );

   ppc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   ppc_back #(
      .PLANE_COUNT     (PLANE_COUNT),
      .MASTER_ENTRIES  (MASTER_ENTRIES),
      .ACTIVE_ENTRIES  (ACTIVE_ENTRIES),
      .PIXELS_PER_WORD (PIXELS_PER_WORD)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   `PPC_ASSERT_NEVER(a_queue_overflow, clock, reset, push.push && queue_full, "queue overflow")
   `PPC_ASSERT_IMPLY(a_pop_has_head, clock, reset, pop, head.valid, "pop from empty queue")
   `PPC_ASSERT_IMPLY(a_pop_free, clock, reset, pop, !(rsp_valid && rsp_stall), "pop in stall")

endmodule

`default_nettype wire
